[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cll_pkg.sv]
// Shared constants, types and helpers of the cell lattice neighbor list
package cll_pkg;
   localparam int MAX_PARTICLES = 1024;
   localparam int GRID_X = 64;
   localparam int GRID_Y = 64;
   localparam int MAX_REACH = 2;

   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CX_W = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int CY_W = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int NX_W = $clog2(GRID_X + 1);
   localparam int NY_W = $clog2(GRID_Y + 1);
   localparam int GRID_DEPTH = GRID_X * GRID_Y;
   localparam int GA_W = $clog2(GRID_DEPTH);
   localparam int R_W = $clog2(MAX_REACH + 1);
   localparam int OFF_W = $clog2(2 * MAX_REACH + 1);

   localparam int POS_W = 24;
   localparam int INV_W = 16;
   localparam int BOX_W = 23;
   localparam int CELLS_W = 7;
   localparam int REACH_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 23;
   localparam int FRAC_W = 20;
   localparam int PROD_W = (POS_W - 1) + INV_W;
   localparam int CELL_W = PROD_W - FRAC_W;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_PLACE = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_CHECK = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_CELL = 3'd0,
      CSR_BOX_X    = 3'd1,
      CSR_BOX_Y    = 3'd2,
      CSR_CELLS_X  = 3'd3,
      CSR_CELLS_Y  = 3'd4,
      CSR_REACH    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_MUL, ST_EVAL, ST_CHK, ST_QRD,
      ST_QLOAD, ST_QMOD, ST_QSET, ST_QISS, ST_QLOOK, ST_FLUSH
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } grid_entry_type;

   typedef struct packed {
      logic [CX_W-1:0] cx;
      logic [CY_W-1:0] cy;
      logic            inbox;
   } pcell_entry_type;

   typedef struct packed {
      logic [CX_W-1:0] cx;
      logic [CY_W-1:0] cy;
      logic            in_range;
      logic            in_box;
   } cell_info_type;

   function automatic logic [GA_W-1:0] grid_addr(input logic [CX_W-1:0] cx,
                                                 input logic [CY_W-1:0] cy);
      grid_addr = GA_W'(cx) * GA_W'(GRID_Y) + GA_W'(cy);
   endfunction
endpackage

[rtl/core/cll_cell_calc.sv]
// Registered position-to-cell multiply and range evaluation
module cll_cell_calc import cll_pkg::*; (
   input  logic                      clock,
   input  logic signed [POS_W-1:0]   pos_x,
   input  logic signed [POS_W-1:0]   pos_y,
   input  logic [INV_W-1:0]          inv_cell,
   input  logic [NX_W-1:0]           nx,
   input  logic [NY_W-1:0]           ny,
   input  logic [BOX_W-1:0]          box_x,
   input  logic [BOX_W-1:0]          box_y,
   output cell_info_type             info
);
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic              neg_x_ff, neg_y_ff, box_ok_ff;
   logic [CELL_W-1:0] cell_x, cell_y;

   always_ff @(posedge clock) begin
      prod_x_ff <= PROD_W'(pos_x[POS_W-2:0]) * PROD_W'(inv_cell);
      prod_y_ff <= PROD_W'(pos_y[POS_W-2:0]) * PROD_W'(inv_cell);
      neg_x_ff  <= pos_x[POS_W-1];
      neg_y_ff  <= pos_y[POS_W-1];
      box_ok_ff <= (pos_x[POS_W-2:0] < box_x) && (pos_y[POS_W-2:0] < box_y);
   end

   always_comb begin
      cell_x = prod_x_ff[PROD_W-1:FRAC_W];
      cell_y = prod_y_ff[PROD_W-1:FRAC_W];
      info.cx = cell_x[CX_W-1:0];
      info.cy = cell_y[CY_W-1:0];
      info.in_range = !neg_x_ff && !neg_y_ff &&
                      (cell_x < CELL_W'(nx)) && (cell_y < CELL_W'(ny));
      info.in_box = box_ok_ff;
   end
endmodule

[rtl/core/cell_lattice_neighbor_list.sv]
// Place and check run the registered cell multiply, then write or compare the grid entry;
// a query of a particle outside the box flushes at once, else it folds the home cell into
// the grid, steps back by reach and reads each of the (2*reach+1)^2 window cells in turn.
// The block takes one item at a time. A clear walks all GRID_X*GRID_Y grid entries, one per cycle.
// Reset (synchronous) restores the CSR and control registers and runs the same grid
// clearing pass; no item is accepted until it ends. Particle cells are not cleared.
module cell_lattice_neighbor_list import cll_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // index, pos_x, pos_y
   input  logic [1:0]            req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // partner, has_partner, stale, out_of_range
   output logic                  rsp_tlast,  // last
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [INV_W-1:0]   inv_ff;
   logic [BOX_W-1:0]   box_x_ff, box_y_ff;
   logic [CELLS_W-1:0] cells_x_ff, cells_y_ff;
   logic [REACH_W-1:0] reach_ff;

   state_type state_ff, state_in;
   kind_type  kind_ff;
   logic [IDX_W-1:0] idx_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [GA_W-1:0] sw_ff, sw_in;
   logic sw_emit_ff, sw_emit_in;
   logic [CX_W-1:0] ix_ff, ix_in;
   logic [CY_W-1:0] iy_ff, iy_in, iy0_ff, iy0_in;
   logic [OFF_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [R_W-1:0] sc_ff, sc_in;
   logic pend_v_ff, pend_v_in;
   logic [IDX_W-1:0] pend_ff, pend_in;
   logic rsp_v_ff, rsp_v_in, last_ff, last_in;
   logic [IDX_W-1:0] partner_ff, partner_in;
   logic has_ff, has_in, stale_ff, stale_in, oor_ff, oor_in;

   logic [NX_W-1:0] nx;
   logic [NY_W-1:0] ny;
   logic [R_W-1:0] r;
   logic [OFF_W-1:0] span;
   cell_info_type info;
   logic slot;
   logic hit;

   grid_entry_type  grid_mem [GRID_DEPTH];
   pcell_entry_type pcell_mem [MAX_PARTICLES];
   grid_entry_type  grid_rd_ff;
   pcell_entry_type pcell_rd_ff;
   logic grid_we, pcell_we;
   logic [GA_W-1:0] grid_waddr, grid_raddr;
   grid_entry_type grid_wdata;
   pcell_entry_type pcell_wdata;

   cll_cell_calc u_calc (
      .clock(clock), .pos_x(pos_x_ff), .pos_y(pos_y_ff), .inv_cell(inv_ff),
      .nx(nx), .ny(ny), .box_x(box_x_ff), .box_y(box_y_ff), .info(info)
   );

   always_comb begin
      nx = (cells_x_ff == '0) ? NX_W'(1) :
           (cells_x_ff > CELLS_W'(GRID_X)) ? NX_W'(GRID_X) : NX_W'(cells_x_ff);
      ny = (cells_y_ff == '0) ? NY_W'(1) :
           (cells_y_ff > CELLS_W'(GRID_Y)) ? NY_W'(GRID_Y) : NY_W'(cells_y_ff);
      r = (reach_ff > REACH_W'(MAX_REACH)) ? R_W'(MAX_REACH) : R_W'(reach_ff);
      span = OFF_W'({r, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 16'd256;
         box_x_ff <= 23'd262144;
         box_y_ff <= 23'd262144;
         cells_x_ff <= 7'd64;
         cells_y_ff <= 7'd64;
         reach_ff <= 2'd2;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INV_CELL: inv_ff <= csr_wdata[INV_W-1:0];
            CSR_BOX_X:    box_x_ff <= csr_wdata[BOX_W-1:0];
            CSR_BOX_Y:    box_y_ff <= csr_wdata[BOX_W-1:0];
            CSR_CELLS_X:  cells_x_ff <= csr_wdata[CELLS_W-1:0];
            CSR_CELLS_Y:  cells_y_ff <= csr_wdata[CELLS_W-1:0];
            CSR_REACH:    reach_ff <= csr_wdata[REACH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      grid_rd_ff <= grid_mem[grid_raddr];
      if (pcell_we) pcell_mem[idx_ff] <= pcell_wdata;
      pcell_rd_ff <= pcell_mem[idx_ff];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign slot = !rsp_v_ff || rsp_tready;
   assign hit = grid_rd_ff.valid && (grid_rd_ff.idx > idx_ff);
   assign grid_raddr = (state_ff == ST_EVAL || state_ff == ST_CHK) ?
                       grid_addr(info.cx, info.cy) : grid_addr(ix_ff, iy_ff);

   always_comb begin
      state_in = state_ff;
      sw_in = sw_ff;
      sw_emit_in = sw_emit_ff;
      ix_in = ix_ff;
      iy_in = iy_ff;
      iy0_in = iy0_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      sc_in = sc_ff;
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready;
      partner_in = partner_ff;
      has_in = has_ff;
      stale_in = stale_ff;
      oor_in = oor_ff;
      last_in = last_ff;
      grid_we = 1'b0;
      grid_waddr = sw_ff;
      grid_wdata = '0;
      pcell_we = 1'b0;
      pcell_wdata = '0;
      case (state_ff)
         ST_SWEEP: begin
            grid_we = 1'b1;
            sw_in = sw_ff + GA_W'(1);
            if (sw_ff == GA_W'(GRID_DEPTH - 1)) begin
               sw_in = '0;
               pend_v_in = 1'b0;
               state_in = sw_emit_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (kind_type'(req_tuser))
                  KIND_CLEAR: begin
                     sw_emit_in = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  KIND_QUERY: state_in = ST_QRD;
                  default: state_in = ST_MUL;
               endcase
            end
         end
         ST_MUL: state_in = ST_EVAL;
         ST_EVAL: begin
            if (kind_ff == KIND_CHECK) begin
               state_in = ST_CHK;
            end else if (slot) begin
               pcell_we = 1'b1;
               if (info.in_range) begin
                  grid_we = 1'b1;
                  grid_waddr = grid_addr(info.cx, info.cy);
                  grid_wdata = '{valid: 1'b1, idx: idx_ff};
                  pcell_wdata = '{cx: info.cx, cy: info.cy, inbox: info.in_box};
               end
               rsp_v_in = 1'b1;
               partner_in = '0;
               has_in = 1'b0;
               stale_in = 1'b0;
               oor_in = !info.in_range;
               last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (slot) begin
               rsp_v_in = 1'b1;
               partner_in = '0;
               has_in = 1'b0;
               stale_in = !(info.in_range && grid_rd_ff.valid && grid_rd_ff.idx == idx_ff);
               oor_in = !info.in_range;
               last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_QRD: state_in = ST_QLOAD;
         ST_QLOAD: begin
            pend_v_in = 1'b0;
            ix_in = pcell_rd_ff.cx;
            iy_in = pcell_rd_ff.cy;
            iy0_in = pcell_rd_ff.cy;
            ox_in = '0;
            oy_in = '0;
            sc_in = '0;
            if (!pcell_rd_ff.inbox) state_in = ST_FLUSH;
            else state_in = ST_QMOD;
         end
         ST_QMOD: begin
            // fold a home cell left over from a larger grid back into the cells in use
            if (NX_W'(ix_ff) >= nx) ix_in = ix_ff - CX_W'(nx);
            if (NY_W'(iy_ff) >= ny) iy_in = iy_ff - CY_W'(ny);
            iy0_in = iy_in;
            if (NX_W'(ix_ff) < nx && NY_W'(iy_ff) < ny) begin
               if (r == '0) state_in = ST_QISS;
               else state_in = ST_QSET;
            end
         end
         ST_QSET: begin
            ix_in = (ix_ff == '0) ? CX_W'(nx - NX_W'(1)) : ix_ff - CX_W'(1);
            iy_in = (iy_ff == '0) ? CY_W'(ny - NY_W'(1)) : iy_ff - CY_W'(1);
            iy0_in = iy_in;
            sc_in = sc_ff + R_W'(1);
            if (sc_ff == r - R_W'(1)) state_in = ST_QISS;
         end
         ST_QISS: state_in = ST_QLOOK;
         ST_QLOOK: begin
            if (!(hit && pend_v_ff && !slot)) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     rsp_v_in = 1'b1;
                     partner_in = pend_ff;
                     has_in = 1'b1;
                     stale_in = 1'b0;
                     oor_in = 1'b0;
                     last_in = 1'b0;
                  end
                  pend_v_in = 1'b1;
                  pend_in = grid_rd_ff.idx;
               end
               state_in = ST_QISS;
               if (oy_ff == span) begin
                  oy_in = '0;
                  iy_in = iy0_ff;
                  if (ox_ff == span) begin
                     state_in = ST_FLUSH;
                  end else begin
                     ox_in = ox_ff + OFF_W'(1);
                     ix_in = (NX_W'(ix_ff) + NX_W'(1) == nx) ? '0 : ix_ff + CX_W'(1);
                  end
               end else begin
                  oy_in = oy_ff + OFF_W'(1);
                  iy_in = (NY_W'(iy_ff) + NY_W'(1) == ny) ? '0 : iy_ff + CY_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (slot) begin
               rsp_v_in = 1'b1;
               partner_in = pend_v_ff ? pend_ff : '0;
               has_in = pend_v_ff;
               stale_in = 1'b0;
               oor_in = 1'b0;
               last_in = 1'b1;
               pend_v_in = 1'b0;
               sw_emit_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sw_ff <= '0;
         sw_emit_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sw_ff <= sw_in;
         sw_emit_ff <= sw_emit_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= kind_type'(req_tuser);
         idx_ff <= req_tdata[IDX_W-1:0];
         pos_x_ff <= req_tdata[33:10];
         pos_y_ff <= req_tdata[57:34];
      end
      ix_ff <= ix_in;
      iy_ff <= iy_in;
      iy0_ff <= iy0_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      sc_ff <= sc_in;
      pend_ff <= pend_in;
      partner_ff <= partner_in;
      has_ff <= has_in;
      stale_ff <= stale_in;
      oor_ff <= oor_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {3'b000, oor_ff, stale_ff, has_ff, partner_ff};
endmodule

[rtl/core/cll_checker.sv]
// Port-level checker for the cell lattice neighbor list, bound to the top level
`include "assert_macros.svh"
module cll_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `ASSERT_CLK(a_nopartner_last, clock, reset, rsp_tvalid && !rsp_tdata[10] |-> rsp_tlast, "no-partner result not last")
   `ASSERT_CLK(a_stale_alone, clock, reset, rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[10] && rsp_tlast, "stale with partner")
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")
endmodule

bind cell_lattice_neighbor_list cll_checker u_cll_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
